// ===== hw/rtl/v3mu_pkg.sv =====
`timescale 1ns / 1ps
package v3mu_pkg;

  // Number format and derived widths
  localparam int DW     = 32;          // data word
  localparam int FW     = 16;          // fraction bits
  localparam int PW     = 2 * DW;      // full product
  localparam int NW     = DW + FW;     // scaled numerator / quotient
  localparam int SQ_ST  = PW / 2;      // square root stages, one result bit each
  localparam int DIV_ST = NW;          // divider stages, one quotient bit each

  typedef logic signed [DW-1:0] fx_t;
  typedef logic [DW-1:0]        mag_t;
  typedef logic [2:0][DW-1:0]   vec_t;

  localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_ADDS  = 4'd4,
    OP_SUBS  = 4'd5,
    OP_MULS  = 4'd6,
    OP_DIVS  = 4'd7,
    OP_CMP   = 4'd8,
    OP_MAG   = 4'd9,
    OP_NORM  = 4'd10,
    OP_DOT   = 4'd11,
    OP_CROSS = 4'd12,
    OP_DIR   = 4'd13
  } op_e;

  // Front end result, handed to the square root pipe
  typedef struct packed {
    op_e             op;
    vec_t            res;     // add/sub/mul/cross result, else zero
    fx_t             sc;      // dot product, else zero
    logic            eq;      // compare result
    logic [PW-1:0]   sq_sum;  // sum of squares of the vector to normalize
    vec_t            num;     // numerators for the dividers
    vec_t            babs;    // element divisor magnitudes
    logic [2:0]      bneg;    // element divisor signs
  } fr_t;

  // Sideband that rides alongside the dividers
  typedef struct packed {
    op_e   op;
    vec_t  res;
    fx_t   sc;
    logic  eq;
    mag_t  root;
  } side_t;

endpackage

// ===== hw/rtl/v3mu_front.sv =====
`timescale 1ns / 1ps
module v3mu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [3:0]           in_op,
  input  v3mu_pkg::vec_t       in_a,
  input  v3mu_pkg::vec_t       in_b,
  input  v3mu_pkg::fx_t        in_s,
  output logic                 out_valid,
  output v3mu_pkg::fr_t        out
);

  localparam int DW = v3mu_pkg::DW;
  localparam int FW = v3mu_pkg::FW;
  localparam int PW = v3mu_pkg::PW;

  // Clamp a one-bit-grown sum to the data word
  function automatic v3mu_pkg::fx_t sat_w(input logic [DW:0] v);
    if (v[DW] != v[DW-1]) return v[DW] ? v3mu_pkg::FX_MIN : v3mu_pkg::FX_MAX;
    return v3mu_pkg::fx_t'(v[DW-1:0]);
  endfunction

  // Clamp a one-bit-grown sum to the product word
  function automatic logic [PW-1:0] sat_p(input logic [PW:0] v);
    if (v[PW] != v[PW-1]) return v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    return v[PW-1:0];
  endfunction

  // Round half up, drop fraction bits, clamp to the data word
  function automatic v3mu_pkg::fx_t round_frac(input logic [PW-1:0] p);
    logic [PW:0]          t;
    logic signed [PW-1:0] sh;
    t  = {p[PW-1], p} + (PW+1)'(1 << (FW - 1));
    sh = $signed(sat_p(t)) >>> FW;
    if (sh[PW-1:DW-1] != '0 && sh[PW-1:DW-1] != '1)
      return sh[PW-1] ? v3mu_pkg::FX_MIN : v3mu_pkg::FX_MAX;
    return v3mu_pkg::fx_t'(sh[DW-1:0]);
  endfunction

  // Operand selection and linear ops
  logic            scl;
  logic [3:0]      bop;
  v3mu_pkg::vec_t  eb, dv, lin;

  always_comb begin
    scl = in_op[2] && !in_op[3];
    bop = scl ? {2'b00, in_op[1:0]} : in_op;
    for (int i = 0; i < 3; i++) begin
      eb[i]  = scl ? in_s : in_b[i];
      dv[i]  = sat_w({eb[i][DW-1], eb[i]} - {in_a[i][DW-1], in_a[i]});
      lin[i] = (bop == v3mu_pkg::OP_ADD) ?
               sat_w({in_a[i][DW-1], in_a[i]} + {eb[i][DW-1], eb[i]}) :
               sat_w({in_a[i][DW-1], in_a[i]} - {eb[i][DW-1], eb[i]});
    end
  end

  // Stage 1 registers
  logic            vld1;
  v3mu_pkg::op_e   op1;
  v3mu_pkg::vec_t  a1, b1, v1, lin1;
  logic            eq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
    end
    if (en) begin
      op1  <= v3mu_pkg::op_e'(bop);
      a1   <= in_a;
      b1   <= eb;
      v1   <= (bop == v3mu_pkg::OP_DIR) ? dv : in_a;
      lin1 <= lin;
      eq1  <= (in_a == eb);
    end
  end

  // Stage 2: all products
  logic                  vld2;
  v3mu_pkg::op_e         op2;
  v3mu_pkg::vec_t        lin2, num2, babs2;
  logic [2:0]            bneg2;
  logic                  eq2;
  logic [2:0][PW-1:0]    prod2, sq2;
  logic [5:0][PW-1:0]    cp2;
  logic [2:0][PW-1:0]    prod_c, sq_c;
  logic [5:0][PW-1:0]    cp_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = $signed(a1[i]) * $signed(b1[i]);
      sq_c[i]   = $signed(v1[i]) * $signed(v1[i]);
    end
    cp_c[0] = $signed(a1[1]) * $signed(b1[2]);
    cp_c[1] = $signed(a1[2]) * $signed(b1[1]);
    cp_c[2] = $signed(a1[2]) * $signed(b1[0]);
    cp_c[3] = $signed(a1[0]) * $signed(b1[2]);
    cp_c[4] = $signed(a1[0]) * $signed(b1[1]);
    cp_c[5] = $signed(a1[1]) * $signed(b1[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
    if (en) begin
      op2   <= op1;
      lin2  <= lin1;
      eq2   <= eq1;
      prod2 <= prod_c;
      sq2   <= sq_c;
      cp2   <= cp_c;
      for (int i = 0; i < 3; i++) begin
        num2[i]  <= (op1 == v3mu_pkg::OP_DIV) ? a1[i] : v1[i];
        babs2[i] <= b1[i][DW-1] ? (~b1[i] + 1'b1) : b1[i];
        bneg2[i] <= b1[i][DW-1];
      end
    end
  end

  // Stage 3: first sums, element product rounding
  logic                  vld3;
  v3mu_pkg::op_e         op3;
  v3mu_pkg::vec_t        res3, num3, babs3;
  logic [2:0]            bneg3;
  logic                  eq3;
  logic [PW-1:0]         s01_3, p2_3, sqs3;
  logic [2:0][PW-1:0]    cd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
    if (en) begin
      op3   <= op2;
      eq3   <= eq2;
      num3  <= num2;
      babs3 <= babs2;
      bneg3 <= bneg2;
      s01_3 <= sat_p({prod2[0][PW-1], prod2[0]} + {prod2[1][PW-1], prod2[1]});
      p2_3  <= prod2[2];
      sqs3  <= sq2[0] + sq2[1] + sq2[2];
      for (int i = 0; i < 3; i++) begin
        cd3[i] <= sat_p({cp2[2*i][PW-1], cp2[2*i]} - {cp2[2*i+1][PW-1], cp2[2*i+1]});
        case (op2)
          v3mu_pkg::OP_ADD, v3mu_pkg::OP_SUB: res3[i] <= lin2[i];
          v3mu_pkg::OP_MUL:                   res3[i] <= round_frac(prod2[i]);
          default:                            res3[i] <= '0;
        endcase
      end
    end
  end

  // Stage 4: dot sum, cross rounding
  logic                  vld4;
  v3mu_pkg::op_e         op4;
  v3mu_pkg::vec_t        res4, num4, babs4;
  logic [2:0]            bneg4;
  logic                  eq4;
  logic [PW-1:0]         dot4, sqs4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld3;
    end
    if (en) begin
      op4   <= op3;
      eq4   <= eq3;
      num4  <= num3;
      babs4 <= babs3;
      bneg4 <= bneg3;
      sqs4  <= sqs3;
      dot4  <= sat_p({s01_3[PW-1], s01_3} + {p2_3[PW-1], p2_3});
      for (int i = 0; i < 3; i++) begin
        res4[i] <= (op3 == v3mu_pkg::OP_CROSS) ? round_frac(cd3[i]) : res3[i];
      end
    end
  end

  // Stage 5: dot rounding, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld4;
    end
    if (en) begin
      out.op     <= op4;
      out.res    <= res4;
      out.sc     <= (op4 == v3mu_pkg::OP_DOT) ? round_frac(dot4) : '0;
      out.eq     <= (op4 == v3mu_pkg::OP_CMP) ? eq4 : 1'b0;
      out.sq_sum <= sqs4;
      out.num    <= num4;
      out.babs   <= babs4;
      out.bneg   <= bneg4;
    end
  end

endmodule

// ===== hw/rtl/v3mu_isqrt.sv =====
`timescale 1ns / 1ps
module v3mu_isqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  v3mu_pkg::fr_t      in,
  output logic               out_valid,
  output v3mu_pkg::fr_t      out,
  output v3mu_pkg::mag_t     out_root
);

  localparam int PW = v3mu_pkg::PW;
  localparam int DW = v3mu_pkg::DW;
  localparam int ST = v3mu_pkg::SQ_ST;

  logic [PW-1:0]   rem  [ST+1];
  logic [PW-1:0]   root [ST+1];
  v3mu_pkg::fr_t   side [ST+1];
  logic            vld  [ST+1];

  assign rem[0]  = in.sq_sum;
  assign root[0] = '0;
  assign side[0] = in;
  assign vld[0]  = in_valid;

  // One result bit per stage, trial bit walks down two places a stage
  for (genvar k = 0; k < ST; k++) begin : g_st
    localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * k);
    logic [PW-1:0] cand;
    logic          ge;
    assign cand = root[k] + BIT;
    assign ge   = rem[k] >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        side[k+1] <= side[k];
        rem[k+1]  <= ge ? rem[k] - cand : rem[k];
        root[k+1] <= ge ? (root[k] >> 1) + BIT : root[k] >> 1;
      end
    end
  end

  assign out_valid = vld[ST];
  assign out       = side[ST];
  assign out_root  = root[ST][DW-1:0];

endmodule

// ===== hw/rtl/v3mu_div.sv =====
`timescale 1ns / 1ps
module v3mu_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  v3mu_pkg::mag_t   in_mag,   // numerator magnitude
  input  v3mu_pkg::mag_t   in_dvs,   // divisor magnitude
  input  logic             in_neg,   // quotient sign
  output logic             out_valid,
  output v3mu_pkg::fx_t    out_q,
  output logic             out_dz
);

  localparam int DW = v3mu_pkg::DW;
  localparam int FW = v3mu_pkg::FW;
  localparam int NW = v3mu_pkg::NW;
  localparam int ST = v3mu_pkg::DIV_ST;

  logic [DW-1:0]  rem [ST+1];
  logic [NW-1:0]  nq  [ST+1];   // numerator bits out the top, quotient bits in
  logic [DW-1:0]  dvs [ST+1];
  logic           neg [ST+1];
  logic           dz  [ST+1];
  logic           mz  [ST+1];
  logic           vld [ST+1];

  assign rem[0] = '0;
  assign nq[0]  = {in_mag, {FW{1'b0}}};
  assign dvs[0] = in_dvs;
  assign neg[0] = in_neg;
  assign dz[0]  = (in_dvs == '0);
  assign mz[0]  = (in_mag == '0);
  assign vld[0] = in_valid;

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < ST; k++) begin : g_st
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem[k], nq[k][NW-1]};
    assign ge = t >= {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1] <= ge ? DW'(t - {1'b0, dvs[k]}) : t[DW-1:0];
        nq[k+1]  <= {nq[k][NW-2:0], ge};
        dvs[k+1] <= dvs[k];
        neg[k+1] <= neg[k];
        dz[k+1]  <= dz[k];
        mz[k+1]  <= mz[k];
      end
    end
  end

  // Sign and saturation of the final quotient
  logic [NW-1:0] q;
  assign q = nq[ST];

  always_comb begin
    if (dz[ST]) begin
      out_q = mz[ST] ? '0 : (neg[ST] ? v3mu_pkg::FX_MIN : v3mu_pkg::FX_MAX);
    end else if (neg[ST]) begin
      out_q = (q > NW'({1'b1, {(DW-1){1'b0}}})) ? v3mu_pkg::FX_MIN :
              v3mu_pkg::fx_t'(~q[DW-1:0] + 1'b1);
    end else begin
      out_q = (q > NW'(v3mu_pkg::FX_MAX)) ? v3mu_pkg::FX_MAX : v3mu_pkg::fx_t'(q[DW-1:0]);
    end
  end

  assign out_dz    = dz[ST];
  assign out_valid = vld[ST];

endmodule

// ===== hw/rtl/vec3_math_unit.sv =====
`timescale 1ns / 1ps
// Pipeline stages: 5 front, 32 square root, 48 divider and 1 output register,
// the same path for every operation.
// Throughput: one request per cycle; the pipeline advances whenever the
// output register is empty or being taken, and freezes as a whole otherwise.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module vec3_math_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [223:0]  s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [3:0]    s_tuser,   // operation
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [135:0]  m_tdata    // r_x, r_y, r_z, scalar_out, equal_flag,
                                   // div_zero_flag, zero pad
);

  localparam int DW = v3mu_pkg::DW;
  localparam int ST = v3mu_pkg::DIV_ST;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Unpack request
  v3mu_pkg::vec_t in_a, in_b;
  v3mu_pkg::fx_t  in_s;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_tdata[i*DW +: DW];
      in_b[i] = s_tdata[(i+3)*DW +: DW];
    end
    in_s = s_tdata[6*DW +: DW];
  end

  // Products, sums and linear ops
  logic           fr_vld;
  v3mu_pkg::fr_t  fr;
  v3mu_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_op(s_tuser), .in_a(in_a), .in_b(in_b), .in_s(in_s),
    .out_valid(fr_vld), .out(fr)
  );

  // Vector length
  logic            sq_vld;
  v3mu_pkg::fr_t   sq;
  v3mu_pkg::mag_t  root;
  v3mu_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fr_vld), .in(fr),
    .out_valid(sq_vld), .out(sq), .out_root(root)
  );

  // Divider operand selection and three lanes
  logic                 elem;
  logic [2:0]           dv_vld, dv_dz;
  v3mu_pkg::vec_t       dv_q;
  assign elem = (sq.op == v3mu_pkg::OP_DIV);

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic            sgn;
    v3mu_pkg::mag_t  nmag;
    v3mu_pkg::fx_t   q;
    assign sgn  = sq.num[i][DW-1];
    assign nmag = sgn ? (~sq.num[i] + 1'b1) : sq.num[i];
    v3mu_div u_div (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sq_vld), .in_mag(nmag),
      .in_dvs(elem ? sq.babs[i] : root),
      .in_neg(sgn ^ (elem && sq.bneg[i])),
      .out_valid(dv_vld[i]), .out_q(q), .out_dz(dv_dz[i])
    );
    assign dv_q[i] = q;
  end

  // Sideband delay matching the dividers
  v3mu_pkg::side_t sd [ST+1];
  assign sd[0].op   = sq.op;
  assign sd[0].res  = sq.res;
  assign sd[0].sc   = sq.sc;
  assign sd[0].eq   = sq.eq;
  assign sd[0].root = root;

  for (genvar k = 0; k < ST; k++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  // Result merge
  v3mu_pkg::side_t  se;
  logic             qsel, dz;
  v3mu_pkg::vec_t   rv;
  v3mu_pkg::fx_t    sc;
  always_comb begin
    se   = sd[ST];
    qsel = (se.op == v3mu_pkg::OP_DIV) || (se.op == v3mu_pkg::OP_NORM) ||
           (se.op == v3mu_pkg::OP_DIR);
    rv   = qsel ? dv_q : se.res;
    dz   = qsel && (|dv_dz);
    case (se.op)
      v3mu_pkg::OP_MAG: sc = se.root[DW-1] ? v3mu_pkg::FX_MAX : v3mu_pkg::fx_t'(se.root);
      default:          sc = se.sc;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld[0];
    end
    if (en) begin
      m_tdata <= {6'b0, dz, se.eq, sc, rv};
    end
  end

  // Compare never reports a divide by zero
  a_eq_no_dz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[128] && m_tdata[129]))
    else $error("equal and divide-by-zero flags both set");

  // Compare leaves the data fields zero
  a_eq_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[128]) |-> (m_tdata[127:0] == '0))
    else $error("compare result carries nonzero data");

  // Divider lanes stay in lockstep
  a_lanes_sync: assert property (@(posedge clk) disable iff (rst)
    (dv_vld[0] == dv_vld[1]) && (dv_vld[1] == dv_vld[2]))
    else $error("divider lanes out of step");

  // A stall freezes the pipeline tail
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_vld[0]))
    else $error("pipeline moved during stall");

endmodule
